### rtl/v3au_pkg.sv
// Shared types, operation codes and helpers for the three-component vector unit.
package v3au_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W   = 4;
   localparam int TOL_W  = 17;
   localparam int NLANES = 3;

   localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
   localparam logic [OP_W-1:0] OP_SCALE   = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
   localparam logic [OP_W-1:0] OP_NEG     = 4'd4;
   localparam logic [OP_W-1:0] OP_DOT     = 4'd5;
   localparam logic [OP_W-1:0] OP_SQLEN   = 4'd6;
   localparam logic [OP_W-1:0] OP_LEN     = 4'd7;
   localparam logic [OP_W-1:0] OP_NORM    = 4'd8;
   localparam logic [OP_W-1:0] OP_CROSS   = 4'd9;
   localparam logic [OP_W-1:0] OP_UCROSS  = 4'd10;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   // Clip a wide signed value into a word; flag when clipped.
   function automatic logic [WORD_W:0] clip_word(input logic signed [71:0] v);
      logic [WORD_W:0] r;
      if (v > 72'sh0_0000_0000_7fff_ffff) begin
         r = {1'b1, WORD_MAX};
      end else if (v < -72'sh0_0000_0000_8000_0000) begin
         r = {1'b1, WORD_MIN};
      end else begin
         r = {1'b0, v[WORD_W-1:0]};
      end
      return r;
   endfunction

endpackage

### rtl/v3au_lane.sv
// One vector lane: add, subtract, negate, scale and two multipliers for cross terms.
module v3au_lane import v3au_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [OP_W-1:0]           op,
   input  logic signed [WORD_W-1:0]  a_val,
   input  logic signed [WORD_W-1:0]  b_val,
   input  logic signed [WORD_W-1:0]  m1_x,
   input  logic signed [WORD_W-1:0]  m1_y,
   input  logic signed [WORD_W-1:0]  m2_x,
   input  logic signed [WORD_W-1:0]  m2_y,
   input  logic signed [WORD_W-1:0]  scale_value,
   output logic signed [WORD_W-1:0]  simple_res,
   output logic                      simple_sat,
   output logic signed [63:0]        prod1,
   output logic signed [63:0]        prod2
);

   logic signed [63:0]       prod1_ff, prod2_ff;
   logic signed [WORD_W-1:0] simple_ff;
   logic                     sat_ff;
   logic signed [71:0]       wide;
   logic [WORD_W:0]          clipped;
   logic signed [63:0]       sp;

   always_comb begin
      sp = 64'(a_val) * 64'(scale_value);
      case (op)
         OP_ADD:   wide = 72'(a_val) + 72'(b_val);
         OP_SUB:   wide = 72'(a_val) - 72'(b_val);
         OP_NEG:   wide = -72'(a_val);
         OP_SCALE: wide = 72'(sp >>> FRAC_BITS);
         default:  wide = '0;
      endcase
      clipped = clip_word(wide);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod1_ff  <= 64'(m1_x) * 64'(m1_y);
         prod2_ff  <= 64'(m2_x) * 64'(m2_y);
         simple_ff <= clipped[WORD_W-1:0];
         sat_ff    <= clipped[WORD_W];
      end
   end

   assign prod1      = prod1_ff;
   assign prod2      = prod2_ff;
   assign simple_res = simple_ff;
   assign simple_sat = sat_ff;

endmodule

### rtl/v3au_div.sv
// Pipelined restoring divider: one quotient bit per stage, truncates toward zero.
module v3au_div import v3au_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 33
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [NUM_W-1:0]  num,
   input  logic signed [DEN_W-1:0]  den,
   output logic signed [NUM_W:0]    quo
);

   localparam int STAGES = NUM_W;

   logic [NUM_W-1:0]  q_ff   [STAGES+1];
   logic [NUM_W-1:0]  n_ff   [STAGES+1];
   logic [DEN_W-1:0]  d_ff   [STAGES+1];
   logic [DEN_W:0]    r_ff   [STAGES+1];
   logic              neg_ff [STAGES+1];

   always_comb begin
      n_ff[0]   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      d_ff[0]   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_ff[0] = num[NUM_W-1] ^ den[DEN_W-1];
      r_ff[0]   = '0;
      q_ff[0]   = '0;
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DEN_W+1:0] trial;
      logic [DEN_W+1:0] diff;
      always_comb begin
         trial = {r_ff[s], n_ff[s][NUM_W-1-s]};
         diff  = trial - (DEN_W+2)'(d_ff[s]);
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[s+1]   <= n_ff[s];
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            if (!diff[DEN_W+1]) begin
               r_ff[s+1] <= diff[DEN_W:0];
               q_ff[s+1] <= q_ff[s] | (NUM_W'(1) << (NUM_W-1-s));
            end else begin
               r_ff[s+1] <= trial[DEN_W:0];
               q_ff[s+1] <= q_ff[s];
            end
         end
      end
   end

   assign quo = neg_ff[STAGES] ? -(NUM_W+1)'({1'b0, q_ff[STAGES]})
                               : (NUM_W+1)'({1'b0, q_ff[STAGES]});

endmodule

### rtl/v3au_sqrt.sv
// Pipelined integer square root of a 66-bit value, one result bit per stage.
module v3au_sqrt import v3au_pkg::*; #(
   parameter int IN_W = 66
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [IN_W-1:0]    val,
   output logic [IN_W/2-1:0]  root
);

   localparam int STAGES = IN_W / 2;

   logic [IN_W-1:0]    v_ff [STAGES+1];
   logic [IN_W/2-1:0]  q_ff [STAGES+1];
   logic [IN_W/2+1:0]  r_ff [STAGES+1];

   always_comb begin
      v_ff[0] = val;
      q_ff[0] = '0;
      r_ff[0] = '0;
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [IN_W/2+3:0] trial;
      logic [IN_W/2+3:0] sub;
      logic [IN_W/2+3:0] diff;
      always_comb begin
         trial = {r_ff[s], v_ff[s][IN_W-1-2*s -: 2]};
         sub   = (IN_W/2+4)'({q_ff[s], 2'b01});
         diff  = trial - sub;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            v_ff[s+1] <= v_ff[s];
            if (!diff[IN_W/2+3]) begin
               r_ff[s+1] <= diff[IN_W/2+1:0];
               q_ff[s+1] <= {q_ff[s][IN_W/2-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= trial[IN_W/2+1:0];
               q_ff[s+1] <= {q_ff[s][IN_W/2-2:0], 1'b0};
            end
         end
      end
   end

   assign root = q_ff[STAGES];

endmodule

### rtl/vector3_arithmetic_unit.sv
// Top level of the three-component vector unit: lanes, merge, sqrt and divide pipes.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: a_x,a_y,a_z,b_x,b_y,b_z,scale; tuser op
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: res_x,res_y,res_z,res_scalar,flags
//  csr     | in  | csr_valid/csr_ready   | csr_data: normalize length tolerance
//
// One beat enters every cycle while the output is free. Every beat runs the full
// fixed-depth pipeline, whatever its op: 103 register stages (four front stages,
// 33 root stages, one select stage, 64 divider stages, output register).
// Synchronous reset clears the valid bits and sets the tolerance to 1. A stalled
// output freezes the whole pipe.
module vector3_arithmetic_unit import v3au_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [223:0]  req_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, scale_value
   input  logic [3:0]    req_tuser,  // op
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,  // res_x,res_y,res_z,res_scalar,degenerate,saturated
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [TOL_W-1:0] csr_data
);

   localparam int SQ_W  = 66;
   localparam int RT_W  = SQ_W / 2;
   localparam int DV_W  = 64;
   localparam int DLAT  = DV_W;
   localparam int SLAT  = RT_W;

   // Per-beat sideband carried down the pipe.
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] ax, ay, az, s;
      logic                     sat;
   } side_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   logic [TOL_W-1:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_W'(1);
      else if (csr_valid) tol_ff <= csr_data;
   end

   logic signed [WORD_W-1:0] a [3], b [3], sv;
   assign sv = req_tdata[223:192];
   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign a[i] = req_tdata[32*i +: 32];
      assign b[i] = req_tdata[96+32*i +: 32];
   end

   // Stage 1: lanes. Lane i products: dot/square a*b or a*a; cross terms.
   logic signed [WORD_W-1:0] simp [3];
   logic                     simp_sat [3];
   logic signed [63:0]       p1 [3], p2 [3], pd [3];
   localparam int P [3] = '{1, 2, 0};
   localparam int Q [3] = '{2, 0, 1};
   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [WORD_W-1:0] m1y;
      assign m1y = (req_tuser == OP_DOT) ? b[i] : a[i];
      v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .enable(adv), .op(req_tuser), .a_val(a[i]), .b_val(b[i]),
         .m1_x(a[P[i]]), .m1_y(b[Q[i]]), .m2_x(a[Q[i]]), .m2_y(b[P[i]]),
         .scale_value(sv), .simple_res(simp[i]), .simple_sat(simp_sat[i]),
         .prod1(p1[i]), .prod2(p2[i]));
      always_ff @(posedge clock) if (adv) pd[i] <= 64'(a[i]) * 64'(m1y);
   end

   logic     v1_ff;
   side_type s1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.op <= req_tuser; s1_ff.ax <= a[0]; s1_ff.ay <= a[1];
         s1_ff.az <= a[2]; s1_ff.s <= sv; s1_ff.sat <= 1'b0;
      end
   end

   // Stage 2: merge. Cross components, dot and square sums.
   logic signed [WORD_W-1:0] cr2_ff [3];
   logic                     crsat2_ff;
   logic signed [WORD_W-1:0] scal2_ff;
   logic                     ssat2_ff;
   logic [SQ_W-1:0]          sq2_ff;
   logic signed [WORD_W-1:0] simp2_ff [3];
   logic                     simpsat2_ff;
   logic                     v2_ff;
   side_type                 s2_ff;
   logic signed [71:0]       crw [3], dotw, sqw;
   logic [WORD_W:0]          crc [3], dotc;
   logic [SQ_W-1:0]          sqsum;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crw[i] = 72'(p1[i]) - 72'(p2[i]);
         crw[i] = crw[i] >>> FRAC_BITS;
         crc[i] = clip_word(crw[i]);
      end
      dotw = (72'(pd[0]) + 72'(pd[1]) + 72'(pd[2])) >>> FRAC_BITS;
      dotc = clip_word(dotw);
      sqsum = SQ_W'(pd[0]) + SQ_W'(pd[1]) + SQ_W'(pd[2]);
      sqw  = 72'(sqsum >> FRAC_BITS);
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s1_ff;
         for (int i = 0; i < 3; i++) begin
            cr2_ff[i]   <= crc[i][WORD_W-1:0];
            simp2_ff[i] <= simp[i];
         end
         crsat2_ff   <= crc[0][WORD_W] | crc[1][WORD_W] | crc[2][WORD_W];
         simpsat2_ff <= simp_sat[0] | simp_sat[1] | simp_sat[2];
         sq2_ff      <= sqsum;
         if (s1_ff.op == OP_DOT) begin
            scal2_ff <= dotc[WORD_W-1:0]; ssat2_ff <= dotc[WORD_W];
         end else if (sqw > 72'sh7fff_ffff) begin
            scal2_ff <= WORD_MAX; ssat2_ff <= 1'b1;
         end else begin
            scal2_ff <= sqw[WORD_W-1:0]; ssat2_ff <= 1'b0;
         end
      end
   end

   // Unit-cross normalize input: cross result squared sum, fed to the same sqrt pipe.
   // Stage 3 squares the cross components; stage 4 picks the vector to normalize.
   logic signed [63:0] cq3_ff [3];
   logic signed [WORD_W-1:0] cr3_ff [3], simp3_ff [3], scal3_ff;
   logic crsat3_ff, simpsat3_ff, ssat3_ff, v3_ff;
   logic [SQ_W-1:0] sq3_ff;
   side_type s3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cq3_ff[i]   <= 64'(cr2_ff[i]) * 64'(cr2_ff[i]);
            cr3_ff[i]   <= cr2_ff[i];
            simp3_ff[i] <= simp2_ff[i];
         end
         scal3_ff <= scal2_ff; crsat3_ff <= crsat2_ff;
         simpsat3_ff <= simpsat2_ff; ssat3_ff <= ssat2_ff;
         sq3_ff <= sq2_ff; s3_ff <= s2_ff;
      end
   end

   // Stage 4: choose vector (a or clipped cross) and its sum of squares.
   logic signed [WORD_W-1:0] nv4_ff [3], simp4_ff [3], scal4_ff;
   logic [SQ_W-1:0] nsq4_ff;
   logic sat4_ff, ssat4_ff, v4_ff;
   side_type s4_ff;
   logic ucr;
   assign ucr = (s3_ff.op == OP_UCROSS);
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         nv4_ff[0] <= ucr ? cr3_ff[0] : s3_ff.ax;
         nv4_ff[1] <= ucr ? cr3_ff[1] : s3_ff.ay;
         nv4_ff[2] <= ucr ? cr3_ff[2] : s3_ff.az;
         nsq4_ff   <= ucr ? SQ_W'(cq3_ff[0]) + SQ_W'(cq3_ff[1]) + SQ_W'(cq3_ff[2])
                          : sq3_ff;
         for (int i = 0; i < 3; i++)
            simp4_ff[i] <= (s3_ff.op == OP_CROSS) ? cr3_ff[i] : simp3_ff[i];
         sat4_ff  <= ((s3_ff.op == OP_CROSS) || ucr) ? crsat3_ff : simpsat3_ff;
         scal4_ff <= scal3_ff; ssat4_ff <= ssat3_ff; s4_ff <= s3_ff;
      end
   end

   // Square root pipe; sideband delayed alongside.
   logic [RT_W-1:0] root;
   v3au_sqrt #(.IN_W(SQ_W)) u_sqrt (.clock(clock), .enable(adv), .val(nsq4_ff),
      .root(root));

   logic signed [WORD_W-1:0] nvd [SLAT+1][3], simpd [SLAT+1][3], scald [SLAT+1];
   logic satd [SLAT+1], ssatd [SLAT+1], vd [SLAT+1];
   side_type sd [SLAT+1];
   always_comb begin
      nvd[0] = nv4_ff; simpd[0] = simp4_ff; scald[0] = scal4_ff;
      satd[0] = sat4_ff; ssatd[0] = ssat4_ff; vd[0] = v4_ff; sd[0] = s4_ff;
   end
   for (genvar k = 0; k < SLAT; k++) begin : g_sd
      always_ff @(posedge clock) begin
         if (reset) vd[k+1] <= 1'b0;
         else if (adv) vd[k+1] <= vd[k];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            nvd[k+1] <= nvd[k]; simpd[k+1] <= simpd[k]; scald[k+1] <= scald[k];
            satd[k+1] <= satd[k]; ssatd[k+1] <= ssatd[k]; sd[k+1] <= sd[k];
         end
      end
   end

   // Stage after sqrt: length result, divisor select, degenerate test.
   logic signed [WORD_W-1:0] nv5_ff [3], simp5_ff [3], scal5_ff;
   logic sat5_ff, v5_ff, small5_ff, dz5_ff;
   logic signed [RT_W:0] den5_ff;
   side_type s5_ff;
   logic is_norm;
   assign is_norm = (sd[SLAT].op == OP_NORM) || (sd[SLAT].op == OP_UCROSS);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= vd[SLAT];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         nv5_ff <= nvd[SLAT]; simp5_ff <= simpd[SLAT]; s5_ff <= sd[SLAT];
         small5_ff <= RT_W'(tol_ff) >= root;
         dz5_ff <= (sd[SLAT].s == '0);
         den5_ff <= is_norm ? (RT_W+1)'({1'b0, root})
                            : (RT_W+1)'(sd[SLAT].s);
         if (sd[SLAT].op == OP_LEN) begin
            if (root > RT_W'(32'h7fff_ffff)) begin
               scal5_ff <= WORD_MAX; sat5_ff <= 1'b1;
            end else begin
               scal5_ff <= root[WORD_W-1:0]; sat5_ff <= 1'b0;
            end
         end else begin
            scal5_ff <= scald[SLAT]; sat5_ff <= (sd[SLAT].op == OP_DOT ||
               sd[SLAT].op == OP_SQLEN) ? ssatd[SLAT] : satd[SLAT];
         end
      end
   end

   // Three divider lanes.
   logic signed [DV_W:0] quo [3];
   logic signed [DV_W-1:0] dnum [3];
   logic signed [DV_W-1:0] dden;
   assign dden = DV_W'(den5_ff);
   for (genvar i = 0; i < 3; i++) begin : g_div
      assign dnum[i] = DV_W'(nv5_ff[i]) <<< FRAC_BITS;
      v3au_div #(.NUM_W(DV_W), .DEN_W(DV_W)) u_div (.clock(clock), .enable(adv),
         .num(dnum[i]), .den(dden), .quo(quo[i]));
   end

   logic signed [WORD_W-1:0] simpq [DLAT+1][3], scalq [DLAT+1];
   logic satq [DLAT+1], smallq [DLAT+1], dzq [DLAT+1], vq [DLAT+1];
   logic [OP_W-1:0] opq [DLAT+1];
   always_comb begin
      simpq[0] = simp5_ff; scalq[0] = scal5_ff; satq[0] = sat5_ff;
      smallq[0] = small5_ff; dzq[0] = dz5_ff; vq[0] = v5_ff; opq[0] = s5_ff.op;
   end
   for (genvar k = 0; k < DLAT; k++) begin : g_dq
      always_ff @(posedge clock) begin
         if (reset) vq[k+1] <= 1'b0;
         else if (adv) vq[k+1] <= vq[k];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            simpq[k+1] <= simpq[k]; scalq[k+1] <= scalq[k]; satq[k+1] <= satq[k];
            smallq[k+1] <= smallq[k]; dzq[k+1] <= dzq[k]; opq[k+1] <= opq[k];
         end
      end
   end

   // Final merge into the output register.
   logic [WORD_W:0] qc [3];
   logic signed [WORD_W-1:0] rx, ry, rz, rs;
   logic rdeg, rsat;
   logic [OP_W-1:0] fop;
   assign fop = opq[DLAT];
   always_comb begin
      for (int i = 0; i < 3; i++) qc[i] = clip_word(72'(quo[i]));
      rx = '0; ry = '0; rz = '0; rs = '0; rdeg = 1'b0; rsat = 1'b0;
      case (fop)
         OP_ADD, OP_SUB, OP_SCALE, OP_NEG, OP_CROSS: begin
            rx = simpq[DLAT][0]; ry = simpq[DLAT][1]; rz = simpq[DLAT][2];
            rsat = satq[DLAT];
         end
         OP_DOT, OP_SQLEN, OP_LEN: begin
            rs = scalq[DLAT]; rsat = satq[DLAT];
         end
         OP_DIV: begin
            if (dzq[DLAT]) begin
               rx = WORD_MAX; ry = WORD_MAX; rz = WORD_MAX; rdeg = 1'b1;
            end else begin
               rx = qc[0][WORD_W-1:0]; ry = qc[1][WORD_W-1:0]; rz = qc[2][WORD_W-1:0];
               rsat = qc[0][WORD_W] | qc[1][WORD_W] | qc[2][WORD_W];
            end
         end
         OP_NORM, OP_UCROSS: begin
            rsat = satq[DLAT];
            if (smallq[DLAT]) begin
               rdeg = 1'b1;
            end else begin
               rx = qc[0][WORD_W-1:0]; ry = qc[1][WORD_W-1:0]; rz = qc[2][WORD_W-1:0];
               rsat = rsat | qc[0][WORD_W] | qc[1][WORD_W] | qc[2][WORD_W];
            end
         end
         default: ;
      endcase
   end

   logic         out_v_ff;
   logic [135:0] out_d_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= vq[DLAT];
   end
   always_ff @(posedge clock) begin
      if (adv) out_d_ff <= {6'b0, rsat, rdeg, rs, rz, ry, rx};
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   // Output valid holds while the sink stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");
   // Output data holds while the sink stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp data moved");
   // Degenerate results only come from vector ops, so they carry no scalar.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[128] |-> rsp_tdata[127:96] == '0) else $error("deg");

endmodule
